// ----- rtl/ifrx_pkg.sv -----
// Package for the frame receiver: types, codes and sizes shared by the
// receiver top level and its checker.
// No dependencies.
`default_nettype none
package ifrx_pkg;

  localparam int LENGTH_BITS = 16;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [1:0] VERDICT_NEW       = 2'd0;
  localparam logic [1:0] VERDICT_DUPLICATE = 2'd1;
  localparam logic [1:0] VERDICT_REJECT    = 2'd2;

  localparam logic [2:0] REG_ADDRESS = 3'd0;
  localparam logic [2:0] REG_SEQ0    = 3'd1;
  localparam logic [2:0] REG_SEQ1    = 3'd2;
  localparam logic [2:0] REG_READY0  = 3'd3;
  localparam logic [2:0] REG_READY1  = 3'd4;
  localparam logic [2:0] REG_REJECT0 = 3'd5;
  localparam logic [2:0] REG_REJECT1 = 3'd6;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  out_byte;
    logic [7:0]  reply_control;
    logic [1:0]  verdict;
    logic [15:0] payload_length;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/ifrx_in_if.sv -----
// Input channel of the frame receiver: one raw line byte per beat.
// Depends on nothing.
`default_nettype none
interface ifrx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/ifrx_out_if.sv -----
// Result channel of the frame receiver: one payload byte or frame verdict per beat.
// Depends on nothing.
`default_nettype none
interface ifrx_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic [7:0]  reply_control;
  logic [1:0]  verdict;
  logic [15:0] payload_length;
  logic        last;

  modport source (output valid, output out_kind, output out_byte, output reply_control,
                  output verdict, output payload_length, output last, input ready);
  modport sink (input valid, input out_kind, input out_byte, input reply_control,
                input verdict, input payload_length, input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/iframe_receiver_destuff_ack_unit.sv -----
// Results are registered in the result queue before they are shown.
// Throughput: one input beat per cycle while results drain; a beat yields
// at most two results, held in a four-entry result queue that takes a beat
// only while two entries are free. Reset is synchronous and active high:
// it returns the framer to hunting, empties the queue and loads the
// register defaults.
// Depends on ifrx_pkg, ifrx_in_if and ifrx_out_if.
`default_nettype none
module iframe_receiver_destuff_ack_unit
  import ifrx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  ifrx_in_if.sink          rx,
  ifrx_out_if.source       result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_FLAG = 3'd1,
    PH_ADDR = 3'd2,
    PH_CTRL = 3'd3,
    PH_DATA = 3'd4,
    PH_ESC  = 3'd5
  } phase_t;

  typedef logic [LENGTH_BITS-1:0] count_t;

  logic [7:0] address_byte, seq0_control, seq1_control;
  logic [7:0] ready0_control, ready1_control, reject0_control, reject1_control;

  phase_t     phase, phase_next;
  logic       received_seq, received_seq_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_valid, held_valid_next;
  logic [7:0] parity, parity_next;
  count_t     payload_count, payload_count_next;
  logic       last_seq, last_seq_next;

  result_t    res0, res1;
  logic [1:0] n_res;

  result_t    queue [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill;

  logic       accept, pop, cfg_write;
  logic [2:0] reg_index;
  logic [LENGTH_BITS+15:0] count_wide;
  logic [15:0] length_out;

  function automatic count_t sat_inc(input count_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic result_t payload_result(input logic [7:0] b);
    result_t r;
    r = '0;
    r.out_kind = KIND_PAYLOAD;
    r.out_byte = b;
    return r;
  endfunction

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (reg_index)
      REG_ADDRESS: prdata = {24'b0, address_byte};
      REG_SEQ0:    prdata = {24'b0, seq0_control};
      REG_SEQ1:    prdata = {24'b0, seq1_control};
      REG_READY0:  prdata = {24'b0, ready0_control};
      REG_READY1:  prdata = {24'b0, ready1_control};
      REG_REJECT0: prdata = {24'b0, reject0_control};
      REG_REJECT1: prdata = {24'b0, reject1_control};
      default:     prdata = 32'b0;
    endcase
  end

  assign rx.ready     = (fill <= 3'd2);
  assign accept       = rx.valid && rx.ready;
  assign result.valid = (fill != 3'd0);
  assign pop          = result.valid && result.ready;

  assign count_wide = {16'b0, payload_count};
  assign length_out = (count_wide > (LENGTH_BITS+16)'(16'hFFFF)) ?
                      16'hFFFF : count_wide[15:0];

  always_comb begin
    phase_next         = phase;
    received_seq_next  = received_seq;
    held_byte_next     = held_byte;
    held_valid_next    = held_valid;
    parity_next        = parity;
    payload_count_next = payload_count;
    last_seq_next      = last_seq;
    res0               = '0;
    res1               = '0;
    n_res              = 2'd0;

    case (phase)
      PH_FLAG: begin
        if (rx.rx_byte == address_byte) begin
          phase_next = PH_ADDR;
        end else if (rx.rx_byte != FLAG_BYTE) begin
          phase_next = PH_HUNT;
        end
      end
      PH_ADDR: begin
        if (rx.rx_byte == seq0_control) begin
          received_seq_next = 1'b0;
          phase_next        = PH_CTRL;
        end else if (rx.rx_byte == seq1_control) begin
          received_seq_next = 1'b1;
          phase_next        = PH_CTRL;
        end else if (rx.rx_byte == FLAG_BYTE) begin
          phase_next = PH_FLAG;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_CTRL: begin
        if (rx.rx_byte == (address_byte ^ (received_seq ? seq1_control : seq0_control))) begin
          held_byte_next     = 8'h00;
          held_valid_next    = 1'b0;
          parity_next        = 8'h00;
          payload_count_next = '0;
          phase_next         = PH_DATA;
        end else if (rx.rx_byte == FLAG_BYTE) begin
          phase_next = PH_FLAG;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (rx.rx_byte == FLAG_BYTE) begin
          res0                = '0;
          res0.out_kind       = KIND_VERDICT;
          res0.payload_length = length_out;
          if (received_seq == last_seq) begin
            res0.verdict       = VERDICT_DUPLICATE;
            res0.reply_control = received_seq ? ready1_control : ready0_control;
          end else if (held_valid && (held_byte == parity)) begin
            res0.verdict       = VERDICT_NEW;
            res0.reply_control = received_seq ? ready0_control : ready1_control;
            last_seq_next      = received_seq;
          end else begin
            res0.verdict       = VERDICT_REJECT;
            res0.reply_control = received_seq ? reject1_control : reject0_control;
          end
          n_res              = 2'd1;
          held_byte_next     = 8'h00;
          held_valid_next    = 1'b0;
          parity_next        = 8'h00;
          payload_count_next = '0;
          phase_next         = PH_HUNT;
        end else if (rx.rx_byte == ESC_BYTE) begin
          phase_next = PH_ESC;
        end else begin
          if (held_valid) begin
            res0               = payload_result(held_byte);
            n_res              = 2'd1;
            parity_next        = parity ^ held_byte;
            payload_count_next = sat_inc(payload_count);
          end
          held_byte_next  = rx.rx_byte;
          held_valid_next = 1'b1;
        end
      end
      PH_ESC: begin
        phase_next      = PH_DATA;
        held_valid_next = 1'b1;
        if ((rx.rx_byte == ESC_FLAG) || (rx.rx_byte == ESC_ESC)) begin
          if (held_valid) begin
            res0               = payload_result(held_byte);
            n_res              = 2'd1;
            parity_next        = parity ^ held_byte;
            payload_count_next = sat_inc(payload_count);
          end
          held_byte_next = (rx.rx_byte == ESC_FLAG) ? FLAG_BYTE : ESC_BYTE;
        end else begin
          if (held_valid) begin
            res0               = payload_result(held_byte);
            res1               = payload_result(ESC_BYTE);
            n_res              = 2'd2;
            parity_next        = parity ^ held_byte ^ ESC_BYTE;
            payload_count_next = sat_inc(sat_inc(payload_count));
          end else begin
            res0               = payload_result(ESC_BYTE);
            n_res              = 2'd1;
            parity_next        = parity ^ ESC_BYTE;
            payload_count_next = sat_inc(payload_count);
          end
          held_byte_next = rx.rx_byte;
        end
      end
      default: begin
        phase_next = (rx.rx_byte == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
      end
    endcase

    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      received_seq    <= 1'b0;
      held_byte       <= 8'h00;
      held_valid      <= 1'b0;
      parity          <= 8'h00;
      payload_count   <= '0;
      last_seq        <= 1'b1;
      wr_ptr          <= 2'd0;
      rd_ptr          <= 2'd0;
      fill            <= 3'd0;
      address_byte    <= 8'd3;
      seq0_control    <= 8'd0;
      seq1_control    <= 8'd64;
      ready0_control  <= 8'd170;
      ready1_control  <= 8'd171;
      reject0_control <= 8'd84;
      reject1_control <= 8'd85;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        received_seq  <= received_seq_next;
        held_byte     <= held_byte_next;
        held_valid    <= held_valid_next;
        parity        <= parity_next;
        payload_count <= payload_count_next;
        last_seq      <= last_seq_next;
        wr_ptr        <= wr_ptr + n_res;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      fill <= fill + (accept ? {1'b0, n_res} : 3'd0) - {2'b0, pop};
      if (cfg_write) begin
        case (reg_index)
          REG_ADDRESS: address_byte    <= pwdata[7:0];
          REG_SEQ0:    seq0_control    <= pwdata[7:0];
          REG_SEQ1:    seq1_control    <= pwdata[7:0];
          REG_READY0:  ready0_control  <= pwdata[7:0];
          REG_READY1:  ready1_control  <= pwdata[7:0];
          REG_REJECT0: reject0_control <= pwdata[7:0];
          REG_REJECT1: reject1_control <= pwdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (n_res != 2'd0)) begin
      queue[wr_ptr] <= res0;
    end
    if (accept && (n_res == 2'd2)) begin
      queue[wr_ptr + 2'd1] <= res1;
    end
  end

  assign result.out_kind       = queue[rd_ptr].out_kind;
  assign result.out_byte       = queue[rd_ptr].out_byte;
  assign result.reply_control  = queue[rd_ptr].reply_control;
  assign result.verdict        = queue[rd_ptr].verdict;
  assign result.payload_length = queue[rd_ptr].payload_length;
  assign result.last           = queue[rd_ptr].last;

endmodule
`default_nettype wire

// ----- rtl/ifrx_checker.sv -----
// Port-level checks for the frame receiver, attached to the top level by bind.
// Depends on ifrx_pkg and iframe_receiver_destuff_ack_unit.
`default_nettype none
module ifrx_checker
  import ifrx_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_kind,
  input wire logic [7:0]  res_reply,
  input wire logic [1:0]  res_verdict,
  input wire logic [15:0] res_length,
  input wire logic        res_last,
  input wire logic        pready
);

  a_empty_after_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat shown right after reset");

  a_verdict_is_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_kind == KIND_VERDICT)) |-> res_last)
    else $error("verdict beat not marked last");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_kind == KIND_PAYLOAD)) |->
      ((res_reply == 8'h00) && (res_verdict == VERDICT_NEW) && (res_length == 16'h0000)))
    else $error("payload beat carries verdict fields");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_verdict != 2'd3))
    else $error("unknown verdict code");

  a_pready: assert property (@(posedge clk) pready)
    else $error("configuration port stalled");

endmodule

bind iframe_receiver_destuff_ack_unit ifrx_checker u_ifrx_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_kind    (result.out_kind),
  .res_reply   (result.reply_control),
  .res_verdict (result.verdict),
  .res_length  (result.payload_length),
  .res_last    (result.last),
  .pready      (pready)
);
`default_nettype wire
